// File: sv/dwst_pkg.sv
// ---------------------------------------------------------------------------
// dwst_pkg
// Shared widths, defaults, the fixed test pattern table and the result type
// of the delay window sweep trainer.
// ---------------------------------------------------------------------------
package dwst_pkg;

  localparam int unsigned RATIO_W       = 7;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_RATIO_DEF = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned TABLE_WORDS = 14;
  localparam int unsigned TABLE_IDX_W = $clog2(TABLE_WORDS);

  localparam logic [DATA_W-1:0] FIXED_TABLE [TABLE_WORDS] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h00FF_00FF, 32'hFF00_FF00, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h6996_9669, 32'h9669_6996
  };

  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_READBACK = 1'b1;

  typedef struct packed {
    logic [RATIO_W-1:0] set_ratio;
    logic [DATA_W-1:0]  write_pattern;
    logic               done_res;
    logic               found;
    logic [RATIO_W-1:0] window_first;
    logic [RATIO_W-1:0] window_last;
    logic [RATIO_W-1:0] chosen_ratio;
  } dwst_res_t;

endpackage

// File: sv/dwst_if.sv
// ---------------------------------------------------------------------------
// dwst_req_if / dwst_res_if
// Valid/ready channels for training requests and training results.
// ---------------------------------------------------------------------------
interface dwst_req_if import dwst_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output req_type, output read_data, input ready);
  modport sink   (input valid, input req_type, input read_data, output ready);
endinterface

interface dwst_res_if import dwst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] set_ratio;
  logic [DATA_W-1:0]  write_pattern;
  logic               done_res;
  logic               found;
  logic [RATIO_W-1:0] window_first;
  logic [RATIO_W-1:0] window_last;
  logic [RATIO_W-1:0] chosen_ratio;

  modport source (output valid, output set_ratio, output write_pattern, output done_res,
                  output found, output window_first, output window_last,
                  output chosen_ratio, input ready);
  modport sink   (input valid, input set_ratio, input write_pattern, input done_res,
                  input found, input window_first, input window_last,
                  input chosen_ratio, output ready);
endinterface

// File: sv/dwst_pattern.sv
// ---------------------------------------------------------------------------
// dwst_pattern
// Test word generator: fixed table, walking one, walking zero, then the
// test address, selected by the pattern index.
// ---------------------------------------------------------------------------
module dwst_pattern import dwst_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic [$clog2(TABLE_WORDS + 2 * WORD_BITS + 2)-1:0] idx,
  input  logic [DATA_W-1:0]                                  train_addr,
  output logic [WORD_BITS-1:0]                               pattern
);

  localparam int unsigned IDX_W = $clog2(TABLE_WORDS + 2 * WORD_BITS + 2);
  localparam int unsigned SHW   = $clog2(WORD_BITS);

  logic [IDX_W-1:0]     walk_pos;
  logic [IDX_W-1:0]     walk_zero_pos;
  logic [WORD_BITS-1:0] one_walk;
  logic [WORD_BITS-1:0] zero_walk;

  assign walk_pos      = idx - IDX_W'(TABLE_WORDS);
  assign walk_zero_pos = walk_pos - IDX_W'(WORD_BITS);
  assign one_walk      = WORD_BITS'(1) << walk_pos[SHW-1:0];
  assign zero_walk     = ~(WORD_BITS'(1) << walk_zero_pos[SHW-1:0]);

  always_comb begin
    if (idx < IDX_W'(TABLE_WORDS)) begin
      pattern = WORD_BITS'(FIXED_TABLE[idx[TABLE_IDX_W-1:0]]);
    end else if (walk_pos < IDX_W'(WORD_BITS)) begin
      pattern = one_walk;
    end else if (walk_pos < IDX_W'(2 * WORD_BITS)) begin
      pattern = zero_walk;
    end else begin
      pattern = WORD_BITS'(train_addr);
    end
  end

endmodule

// File: sv/dwst_seq.sv
// ---------------------------------------------------------------------------
// dwst_seq
// Sweep sequencer: holds the sweep state, checks each readback against the
// word last issued and forms the report for the updated state.
// ---------------------------------------------------------------------------
module dwst_seq import dwst_pkg::*; #(
  parameter int unsigned MAX_RATIO = MAX_RATIO_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              req_type,
  input  logic [DATA_W-1:0] read_data,
  input  logic [DATA_W-1:0] train_addr,
  output dwst_res_t         res
);

  localparam int unsigned TOTAL_WORDS = TABLE_WORDS + 2 * WORD_BITS + 1;
  localparam int unsigned IDX_W       = $clog2(TOTAL_WORDS + 1);

  logic               sweeping,      sweeping_next;
  logic [RATIO_W-1:0] current_ratio, current_ratio_next;
  logic [IDX_W-1:0]   pattern_index, pattern_index_next;
  logic               window_seen,   window_seen_next;
  logic [RATIO_W-1:0] first_pass,    first_pass_next;
  logic [RATIO_W-1:0] last_pass,     last_pass_next;

  logic [WORD_BITS-1:0] expected;
  logic [WORD_BITS-1:0] next_word;
  logic [IDX_W-1:0]     index_inc;
  logic                 step_setting;
  logic [RATIO_W:0]     mid_sum;
  logic [RATIO_W-1:0]   mid;

  dwst_pattern #(.WORD_BITS(WORD_BITS)) u_expected (
    .idx        (pattern_index),
    .train_addr (train_addr),
    .pattern    (expected)
  );

  dwst_pattern #(.WORD_BITS(WORD_BITS)) u_next_word (
    .idx        (pattern_index_next),
    .train_addr (train_addr),
    .pattern    (next_word)
  );

  assign index_inc = pattern_index + IDX_W'(1);

  always_comb begin
    sweeping_next      = sweeping;
    current_ratio_next = current_ratio;
    pattern_index_next = pattern_index;
    window_seen_next   = window_seen;
    first_pass_next    = first_pass;
    last_pass_next     = last_pass;
    step_setting       = 1'b0;

    if (req_type == REQ_START) begin
      sweeping_next      = 1'b1;
      current_ratio_next = '0;
      pattern_index_next = '0;
      window_seen_next   = 1'b0;
      first_pass_next    = '0;
      last_pass_next     = '0;
    end else if (sweeping) begin
      if (WORD_BITS'(read_data) != expected) begin
        // a failure after a pass closes the window
        if (window_seen) begin
          sweeping_next = 1'b0;
        end else begin
          step_setting = 1'b1;
        end
      end else begin
        pattern_index_next = index_inc;
        if (index_inc >= IDX_W'(TOTAL_WORDS)) begin
          if (!window_seen) begin
            window_seen_next = 1'b1;
            first_pass_next  = current_ratio;
          end
          last_pass_next = current_ratio;
          step_setting   = 1'b1;
        end
      end
    end

    if (step_setting) begin
      if (current_ratio >= RATIO_W'(MAX_RATIO)) begin
        sweeping_next = 1'b0;
      end else begin
        current_ratio_next = current_ratio + RATIO_W'(1);
        pattern_index_next = '0;
      end
    end
  end

  assign mid_sum = {1'b0, first_pass_next} + {1'b0, last_pass_next};
  assign mid     = mid_sum[RATIO_W:1];

  always_comb begin
    res.found        = window_seen_next;
    res.window_first = first_pass_next;
    res.window_last  = last_pass_next;
    res.chosen_ratio = mid;
    if (sweeping_next) begin
      res.set_ratio     = current_ratio_next;
      res.write_pattern = DATA_W'(next_word);
      res.done_res      = 1'b0;
    end else begin
      res.set_ratio     = mid;
      res.write_pattern = '0;
      res.done_res      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping      <= 1'b0;
      current_ratio <= '0;
      pattern_index <= '0;
      window_seen   <= 1'b0;
      first_pass    <= '0;
      last_pass     <= '0;
    end else if (en) begin
      sweeping      <= sweeping_next;
      current_ratio <= current_ratio_next;
      pattern_index <= pattern_index_next;
      window_seen   <= window_seen_next;
      first_pass    <= first_pass_next;
      last_pass     <= last_pass_next;
    end
  end

endmodule

// File: sv/delay_window_sweep_trainer_unit.sv
// ---------------------------------------------------------------------------
// delay_window_sweep_trainer_unit
// Delay window training sequencer with an input register and a result
// register around the sweep sequencer.
// Flow: a request is captured in the input register, then passes the sweep
// sequencer into the result register, which holds it until it is taken.
// Throughput: one request per cycle unless results stall, set by the
// single-pass compare and counter update between the two registers.
// Reset: synchronous; clears the sweep state, test address and both valids.
// ---------------------------------------------------------------------------
module delay_window_sweep_trainer_unit import dwst_pkg::*; #(
  parameter int unsigned MAX_RATIO = MAX_RATIO_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dwst_req_if.sink          req,
  dwst_res_if.source        res,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  logic [DATA_W-1:0] train_addr;

  logic              in_valid;
  logic              in_req_type;
  logic [DATA_W-1:0] in_read_data;

  logic              out_valid;
  dwst_res_t         out_data;
  dwst_res_t         seq_res;
  logic              advance;

  // move the staged request on when the result register is free or draining
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      train_addr <= '0;
    end else if (cfg_wr_en) begin
      train_addr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type  <= req.req_type;
      in_read_data <= req.read_data;
    end
    if (advance) begin
      out_data <= seq_res;
    end
  end

  dwst_seq #(.MAX_RATIO(MAX_RATIO), .WORD_BITS(WORD_BITS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .req_type   (in_req_type),
    .read_data  (in_read_data),
    .train_addr (train_addr),
    .res        (seq_res)
  );

  assign res.valid         = out_valid;
  assign res.set_ratio     = out_data.set_ratio;
  assign res.write_pattern = out_data.write_pattern;
  assign res.done_res      = out_data.done_res;
  assign res.found         = out_data.found;
  assign res.window_first  = out_data.window_first;
  assign res.window_last   = out_data.window_last;
  assign res.chosen_ratio  = out_data.chosen_ratio;

endmodule

// File: sv/dwst_checker.sv
// ---------------------------------------------------------------------------
// dwst_checker
// Port-level checks on the trainer results, bound to the top level.
// ---------------------------------------------------------------------------
module dwst_checker import dwst_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [RATIO_W-1:0] set_ratio,
  input logic [DATA_W-1:0]  write_pattern,
  input logic               done_res,
  input logic               found,
  input logic [RATIO_W-1:0] window_first,
  input logic [RATIO_W-1:0] window_last,
  input logic [RATIO_W-1:0] chosen_ratio
);

  logic [RATIO_W:0] mid_sum;
  assign mid_sum = {1'b0, window_first} + {1'b0, window_last};

  // hold a stalled result transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(set_ratio)
      && $stable(write_pattern) && $stable(done_res) && $stable(chosen_ratio))
    else $error("stalled result changed");

  a_done_report: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> write_pattern == '0 && set_ratio == chosen_ratio)
    else $error("final report does not select the midpoint");

  a_midpoint: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> chosen_ratio == mid_sum[RATIO_W:1])
    else $error("chosen ratio is not the window midpoint");

  a_no_window: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> window_first == '0 && window_last == '0)
    else $error("window bounds set without a passing setting");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result offered right after reset");

endmodule

bind delay_window_sweep_trainer_unit dwst_checker u_dwst_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .set_ratio     (res.set_ratio),
  .write_pattern (res.write_pattern),
  .done_res      (res.done_res),
  .found         (res.found),
  .window_first  (res.window_first),
  .window_last   (res.window_last),
  .chosen_ratio  (res.chosen_ratio)
);
